### hdl/mm3_pkg.sv
package mm3_pkg;

   localparam int HASH_W = 32;
   localparam int BYTE_W = 8;
   localparam int POS_W  = 2;

   localparam logic [HASH_W-1:0] MM_C1 = 32'hcc9e2d51;
   localparam logic [HASH_W-1:0] MM_C2 = 32'h1b873593;
   localparam logic [HASH_W-1:0] MM_N  = 32'he6546b64;
   localparam logic [HASH_W-1:0] MM_F1 = 32'h85ebca6b;
   localparam logic [HASH_W-1:0] MM_F2 = 32'hc2b2ae35;

   function automatic logic [HASH_W-1:0] rotl15(input logic [HASH_W-1:0] x);
      return {x[HASH_W-16:0], x[HASH_W-1:HASH_W-15]};
   endfunction

   // h = rotl13(x) * 5 + n, the times five done as shift and add
   function automatic logic [HASH_W-1:0] mix_word(input logic [HASH_W-1:0] x);
      logic [HASH_W-1:0] r;
      r = {x[HASH_W-14:0], x[HASH_W-1:HASH_W-13]};
      return r + {r[HASH_W-3:0], 2'b00} + MM_N;
   endfunction

endpackage

### hdl/mm3_ifs.sv
interface mm3_req_if import mm3_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              byte_valid;
   logic              last;

   modport source (output valid, data_byte, byte_valid, last, input ready);
   modport sink (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface mm3_rsp_if import mm3_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HASH_W-1:0] hash_value;

   modport source (output valid, hash_value, input ready);
   modport sink (input valid, hash_value, output ready);
endinterface

### hdl/mm3_mul.sv
module mm3_mul import mm3_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [HASH_W-1:0] a,
   input  logic [HASH_W-1:0] b,
   output logic [HASH_W-1:0] p
);

   logic [HASH_W-1:0] prod_ff;
   logic [HASH_W-1:0] prod_in;

   // only the low word of the product is ever needed
   assign prod_in = a * b;
   assign p       = prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

### hdl/murmur3_hash32_stream_core.sv
// channel  dir  handshake              payload
// req      in   req.valid/req.ready    data_byte[7:0], byte_valid, last
// rsp      out  rsp.valid/rsp.ready    hash_value[31:0]
// csr      in   csr_wr_en              csr_wr_data[31:0] (seed)
//
// a request that does not complete a word leaves the core idle for the next one;
// one that completes a word runs S_K1, S_K2, S_KX (two passes through the shared
// multiplier plus the mix). a request with last runs the word mix or tail scramble
// if any, then two finalizer multiplies, all through the one 32x32 multiplier.
// reset is synchronous; seed returns to 0. the hash waits in an output register,
// a new message may start meanwhile, but its hash holds the core until collected.
module murmur3_hash32_stream_core import mm3_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   mm3_req_if.sink           req,
   mm3_rsp_if.source         rsp,
   input  logic              csr_wr_en,
   input  logic [HASH_W-1:0] csr_wr_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_K1   = 3'd1;
   localparam logic [2:0] S_K2   = 3'd2;
   localparam logic [2:0] S_KX   = 3'd3;
   localparam logic [2:0] S_F0   = 3'd4;
   localparam logic [2:0] S_F1   = 3'd5;
   localparam logic [2:0] S_F2   = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [HASH_W-1:0] seed_ff, seed_in;
   logic [HASH_W-1:0] h_ff, h_in;
   logic [HASH_W-1:0] gather_ff, gather_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [HASH_W-1:0] count_ff, count_in;
   logic              mid_ff, mid_in;
   logic              mix_ff, mix_in;
   logic              fin_ff, fin_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0] rsp_hash_ff, rsp_hash_in;

   logic              accept;
   logic [HASH_W-1:0] g_new;
   logic [HASH_W-1:0] fmix0;
   logic              mul_en;
   logic [HASH_W-1:0] mul_a, mul_b, mul_p;

   assign req.ready      = (state_ff == S_IDLE);
   assign accept         = req.valid && req.ready;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.hash_value = rsp_hash_ff;

   // little-endian byte gather
   assign g_new = gather_ff | ({{(HASH_W-BYTE_W){1'b0}}, req.data_byte} << {pos_ff, 3'b000});
   assign fmix0 = (h_ff ^ count_ff) ^ ((h_ff ^ count_ff) >> 16);

   always_comb begin
      mul_en = 1'b1;
      unique case (state_ff)
         S_K1: begin
            mul_a = gather_ff;
            mul_b = MM_C1;
         end
         S_K2: begin
            mul_a = rotl15(mul_p);
            mul_b = MM_C2;
         end
         S_F0: begin
            mul_a = fmix0;
            mul_b = MM_F1;
         end
         S_F1: begin
            mul_a = mul_p ^ (mul_p >> 13);
            mul_b = MM_F2;
         end
         default: begin
            mul_en = 1'b0;
            mul_a  = '0;
            mul_b  = '0;
         end
      endcase
   end

   mm3_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   always_comb begin
      state_in     = state_ff;
      seed_in      = seed_ff;
      h_in         = h_ff;
      gather_in    = gather_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      mid_in       = mid_ff;
      mix_in       = mix_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_hash_in  = rsp_hash_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req.byte_valid) begin
                  gather_in = g_new;
                  pos_in    = pos_ff + 1'b1;
                  count_in  = count_ff + 1'b1;
                  mid_in    = 1'b1;
               end
               fin_in = req.last;
               mix_in = req.byte_valid && (pos_ff == 2'd3);
               if (mix_in) begin
                  state_in = S_K1;
               end else if (req.last) begin
                  // leftover tail bytes get scrambled before the finalizer
                  state_in = (pos_in != '0) ? S_K1 : S_F0;
               end
            end
         end
         S_K1: state_in = S_K2;
         S_K2: state_in = S_KX;
         S_KX: begin
            if (mix_ff) begin
               h_in      = mix_word(h_ff ^ mul_p);
               gather_in = '0;
               state_in  = fin_ff ? S_F0 : S_IDLE;
            end else begin
               h_in     = h_ff ^ mul_p;
               state_in = S_F0;
            end
         end
         S_F0: state_in = S_F1;
         S_F1: state_in = S_F2;
         S_F2: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = mul_p ^ (mul_p >> 16);
               h_in         = seed_ff;
               gather_in    = '0;
               pos_in       = '0;
               count_in     = '0;
               mid_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // a new seed applies at once between messages, else from the next one
      if (csr_wr_en) begin
         seed_in = csr_wr_data;
         if (!mid_ff) begin
            h_in = csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seed_ff      <= '0;
         h_ff         <= '0;
         gather_ff    <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
         mid_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         h_ff         <= h_in;
         gather_ff    <= gather_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         mid_ff       <= mid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mix_ff      <= mix_in;
      fin_ff      <= fin_in;
      rsp_hash_ff <= rsp_hash_in;
   end

`ifndef SYNTHESIS
   a_last_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req.last) |=> (state_ff != S_IDLE))
      else $error("request with last did not start finishing");

   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_F2))
      else $error("response raised outside final step");

   a_final_delivers: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_F2) && !rsp_valid_ff) |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("finished hash not loaded into output register");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !mid_ff |-> ((count_ff == '0) && (pos_ff == '0)))
      else $error("message counters nonzero outside a message");
`endif

endmodule

### dv/murmur3_hash32_stream_core_test.sv
`timescale 1ns / 1ps

module murmur3_hash32_stream_core_test import mm3_pkg::*; ();

   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned QUIET_LIMIT   = 2000;
   localparam int unsigned LONG_HOLD     = 400;
   localparam int unsigned MAX_REPORTS   = 10;

   // running MurmurHash3 x86_32 over the accepted request stream
   class murmur_scoreboard;
      logic [HASH_W-1:0] seed;
      logic [HASH_W-1:0] run_hash;
      logic [HASH_W-1:0] gather;
      logic [HASH_W-1:0] byte_total;
      logic [POS_W-1:0]  pos;
      bit                in_message;
      logic [HASH_W-1:0] expected_hashes[$];
      int unsigned       errors;

      function new();
         seed   = '0;
         errors = 0;
         restart();
      endfunction

      function void restart();
         run_hash   = seed;
         gather     = '0;
         byte_total = '0;
         pos        = '0;
         in_message = 1'b0;
      endfunction

      function void set_seed(input logic [HASH_W-1:0] value);
         seed = value;
         // an open message keeps the seed it started with
         if (!in_message) run_hash = value;
      endfunction

      function logic [HASH_W-1:0] rotate_left(input logic [HASH_W-1:0] x, input int r);
         return (x << r) | (x >> (HASH_W - r));
      endfunction

      function logic [HASH_W-1:0] scramble_word(input logic [HASH_W-1:0] k);
         logic [HASH_W-1:0] t;
         t = k * 32'hcc9e2d51;
         t = rotate_left(t, 15);
         t = t * 32'h1b873593;
         return t;
      endfunction

      function void take_request(input logic [BYTE_W-1:0] data, input logic has_byte,
                                 input logic is_last);
         logic [HASH_W-1:0] h;
         if (has_byte) begin
            gather     = gather | ({24'd0, data} << (8 * pos));
            byte_total = byte_total + 1;
            in_message = 1'b1;
            if (pos == 2'd3) begin
               h        = run_hash ^ scramble_word(gather);
               h        = rotate_left(h, 13);
               run_hash = h * 32'd5 + 32'he6546b64;
               gather   = '0;
               pos      = '0;
            end else begin
               pos = pos + 1'b1;
            end
         end
         if (is_last) begin
            h = run_hash;
            if (pos != 0) h = h ^ scramble_word(gather);
            h = h ^ byte_total;
            h = h ^ (h >> 16);
            h = h * 32'h85ebca6b;
            h = h ^ (h >> 13);
            h = h * 32'hc2b2ae35;
            h = h ^ (h >> 16);
            expected_hashes.push_back(h);
            restart();
         end
      endfunction

      function void check_hash(input logic [HASH_W-1:0] actual);
         logic [HASH_W-1:0] want;
         if (expected_hashes.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: hash 0x%08h arrived with none outstanding", $time, actual);
         end else begin
            want = expected_hashes.pop_front();
            if (actual !== want) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: hash_value mismatch, expected 0x%08h, got 0x%08h",
                           $time, want, actual);
            end
         end
      endfunction

      function int unsigned outstanding();
         return expected_hashes.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [HASH_W-1:0] csr_wr_data;

   mm3_req_if req_ch ();
   mm3_rsp_if rsp_ch ();

   murmur3_hash32_stream_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   murmur_scoreboard sb;
   int unsigned      send_idle_pct;
   int unsigned      recv_idle_pct;
   int unsigned      quiet_cycles;
   bit               hold_asked;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // monitor: feeds the scoreboard and tracks cycles without progress
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            sb.take_request(req_ch.data_byte, req_ch.byte_valid, req_ch.last);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_hash(rsp_ch.hash_value);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      @(posedge clock);
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // hash receiver, with random stalls and one long hold-off on request
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked) begin
            hold_asked = 1'b0;
            hold_left  = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic push_request(input logic [BYTE_W-1:0] data, input logic has_byte,
                               input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.data_byte  <= data;
      req_ch.byte_valid <= has_byte;
      req_ch.last       <= is_last;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
   endtask

   // stop sending, let every hash come back, then give the block time to go idle
   task automatic quiesce();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [HASH_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_seed(value);
   endtask

   // one message of random length and content, with a little noise inside
   task automatic random_message(output int unsigned sent);
      int unsigned len;
      bit          empty_close;
      sent = 0;
      len = ($urandom_range(15) == 0) ? $urandom_range(64) : $urandom_range(9);
      empty_close = (len == 0) || ($urandom_range(2) == 0);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(32) == 0) push_request(BYTE_W'($urandom_range(255)), 1'b0, 1'b0);
         push_request(BYTE_W'($urandom_range(255)), 1'b1, (i == len - 1) && !empty_close);
         sent++;
      end
      if (empty_close) begin
         push_request(BYTE_W'($urandom_range(255)), 1'b0, 1'b1);
         sent++;
      end
   endtask

   task automatic run_messages(input int unsigned total);
      int unsigned done;
      int unsigned n;
      done = 0;
      while (done < total) begin
         random_message(n);
         done += n;
      end
   endtask

   initial begin
      sb = new();
      send_idle_pct = 31;
      recv_idle_pct = 55;
      hold_asked    = 1'b0;
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.data_byte  <= '0;
      req_ch.byte_valid <= 1'b0;
      req_ch.last       <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message under the reset seed, idle request, tails of 1 to 3, whole words
      push_request(8'h00, 1'b0, 1'b1);
      push_request(8'h5a, 1'b0, 1'b0);
      push_request(8'hff, 1'b1, 1'b1);
      push_request(8'h00, 1'b1, 1'b0);
      push_request(8'hff, 1'b1, 1'b0);
      push_request(8'h80, 1'b1, 1'b0);
      push_request(8'h00, 1'b0, 1'b1);
      for (int i = 0; i < 4; i++) push_request(8'hff, 1'b1, i == 3);
      for (int i = 1; i <= 5; i++) push_request(i[7:0], 1'b1, i == 5);
      push_request(8'h10, 1'b1, 1'b0);
      push_request(8'h20, 1'b1, 1'b1);
      quiesce();
      write_seed(32'hffffffff);
      push_request(8'hff, 1'b0, 1'b1);
      push_request(8'haa, 1'b1, 1'b0);
      push_request(8'h55, 1'b1, 1'b1);
      // seed change with a message open: the open one keeps the old seed
      push_request(8'hc3, 1'b1, 1'b0);
      push_request(8'h3c, 1'b1, 1'b0);
      quiesce();
      write_seed(32'h12345678);
      push_request(8'h7e, 1'b1, 1'b0);
      push_request(8'h81, 1'b1, 1'b0);
      push_request(8'he7, 1'b1, 1'b1);
      push_request(8'h00, 1'b0, 1'b1);
      quiesce();

      write_seed($urandom);
      run_messages(640);
      quiesce();

      send_idle_pct = 55;
      recv_idle_pct = 31;
      write_seed(32'h80000000);
      run_messages(320);
      quiesce();
      run_messages(320);
      quiesce();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_seed(32'h00000000);
      // receiver holds off while requests keep coming, so the core backs up
      hold_asked = 1'b1;
      run_messages(640);
      quiesce();

      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
